@@ rtl/dtwq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deduplicating work queue package
// Shared constants, field widths and operation codes for the two-priority
// deduplicating node work queue.
// ----------------------------------------------------------------------------
package dtwq_pkg;

   // Default number of nodes the queue tracks.
   localparam int unsigned NODE_COUNT_DEFAULT = 1024;

   // Fixed widths of the item fields.
   localparam int unsigned NODE_WIDTH  = 10;
   localparam int unsigned TOTAL_WIDTH = 11;

   // Operation codes carried by the opcode field.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

endpackage

@@ rtl/dedup_two_level_work_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deduplicating two-priority work queue
// Two circular node FIFOs (high and low priority) with a membership bitmap
// that keeps any node from being queued twice.
// ----------------------------------------------------------------------------
// For each item, the edge that accepts it (start high while busy is low)
// reads the membership memory and the heads of both rings, and the next edge
// updates the memories and pointers and loads the result registers. The result
// is shown for exactly one cycle with rsp_valid high, and busy is low again in
// that same cycle, so a new item can be accepted while the result is on the
// ports; no new item is accepted while the last one is still being executed.
// The result port has no back-pressure: the receiver must take every result
// in the cycle it appears. After reset the block runs a clearing pass over
// every address of the membership memory, with busy held high.
// ----------------------------------------------------------------------------
module dedup_two_level_work_queue #(
   parameter int unsigned NODE_COUNT = dtwq_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_opcode,
   input  logic [dtwq_pkg::NODE_WIDTH-1:0]  req_node_index,
   input  logic                             req_low_priority,
   output logic                             rsp_valid,
   output logic [dtwq_pkg::NODE_WIDTH-1:0]  rsp_popped_node,
   output logic                             rsp_pop_valid,
   output logic                             rsp_push_ignored,
   output logic                             rsp_pop_empty_error,
   output logic [dtwq_pkg::TOTAL_WIDTH-1:0] rsp_queued_total,
   output logic                             rsp_queue_empty
);

   localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int unsigned CW = $clog2(NODE_COUNT + 1);
   localparam int unsigned NW = dtwq_pkg::NODE_WIDTH;
   localparam int unsigned TW = dtwq_pkg::TOTAL_WIDTH;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);

   // Controller states.
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   // Memories.
   logic          member_mem [NODE_COUNT];
   logic [NW-1:0] high_mem   [NODE_COUNT];
   logic [NW-1:0] low_mem    [NODE_COUNT];

   // Control registers.
   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;
   logic [AW-1:0] high_head_ff, high_head_in;
   logic [AW-1:0] high_tail_ff, high_tail_in;
   logic [CW-1:0] high_count_ff, high_count_in;
   logic [AW-1:0] low_head_ff, low_head_in;
   logic [AW-1:0] low_tail_ff, low_tail_in;
   logic [CW-1:0] low_count_ff, low_count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Captured item and registered memory reads.
   logic          opcode_ff;
   logic [NW-1:0] node_ff;
   logic          low_prio_ff;
   logic          member_rd_ff;
   logic [NW-1:0] high_rd_ff;
   logic [NW-1:0] low_rd_ff;

   // Result registers.
   logic [NW-1:0] popped_ff, popped_in;
   logic          pop_valid_ff, pop_valid_in;
   logic          ignored_ff, ignored_in;
   logic          empty_err_ff, empty_err_in;
   logic [TW-1:0] total_ff, total_in;
   logic          queue_empty_ff, queue_empty_in;

   // Memory write controls.
   logic          member_we;
   logic [AW-1:0] member_wa;
   logic          member_wd;
   logic          high_we;
   logic          low_we;

   logic          accept;
   logic          out_of_range;
   logic [CW:0]   total_sum;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Advance a ring pointer with wrap at the last node.
   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] pos);
      ring_next = (pos == LAST_ADDR) ? '0 : pos + AW'(1);
   endfunction

   assign out_of_range = (32'(node_ff) >= 32'(NODE_COUNT));

   // Decide the update for the item held in the input registers.
   always_comb begin
      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      high_head_in   = high_head_ff;
      high_tail_in   = high_tail_ff;
      high_count_in  = high_count_ff;
      low_head_in    = low_head_ff;
      low_tail_in    = low_tail_ff;
      low_count_in   = low_count_ff;
      rsp_valid_in   = 1'b0;
      popped_in      = '0;
      pop_valid_in   = 1'b0;
      ignored_in     = 1'b0;
      empty_err_in   = 1'b0;
      member_we      = 1'b0;
      member_wa      = AW'(node_ff);
      member_wd      = 1'b0;
      high_we        = 1'b0;
      low_we         = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            member_we     = 1'b1;
            member_wa     = clear_addr_ff;
            clear_addr_in = ring_next(clear_addr_ff);
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (opcode_ff == dtwq_pkg::OP_PUSH) begin
               // A push of a queued or out-of-range node changes nothing.
               if (out_of_range || member_rd_ff) begin
                  ignored_in = 1'b1;
               end else begin
                  member_we = 1'b1;
                  member_wd = 1'b1;
                  if (low_prio_ff) begin
                     low_we        = 1'b1;
                     low_tail_in   = ring_next(low_tail_ff);
                     low_count_in  = low_count_ff + CW'(1);
                  end else begin
                     high_we       = 1'b1;
                     high_tail_in  = ring_next(high_tail_ff);
                     high_count_in = high_count_ff + CW'(1);
                  end
               end
            end else begin
               // A pop serves the high FIFO first, then the low FIFO.
               if (high_count_ff != '0) begin
                  popped_in     = high_rd_ff;
                  pop_valid_in  = 1'b1;
                  high_head_in  = ring_next(high_head_ff);
                  high_count_in = high_count_ff - CW'(1);
               end else if (low_count_ff != '0) begin
                  popped_in     = low_rd_ff;
                  pop_valid_in  = 1'b1;
                  low_head_in   = ring_next(low_head_ff);
                  low_count_in  = low_count_ff - CW'(1);
               end else begin
                  empty_err_in  = 1'b1;
               end
               member_we = pop_valid_in;
               member_wa = AW'(popped_in);
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Totals after this item.
   assign total_sum      = {1'b0, high_count_in} + {1'b0, low_count_in};
   assign total_in       = TW'(total_sum);
   assign queue_empty_in = (total_sum == '0);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         high_head_ff  <= '0;
         high_tail_ff  <= '0;
         high_count_ff <= '0;
         low_head_ff   <= '0;
         low_tail_ff   <= '0;
         low_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         high_head_ff  <= high_head_in;
         high_tail_ff  <= high_tail_in;
         high_count_ff <= high_count_in;
         low_head_ff   <= low_head_in;
         low_tail_ff   <= low_tail_in;
         low_count_ff  <= low_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Item capture and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff   <= req_opcode;
         node_ff     <= req_node_index;
         low_prio_ff <= req_low_priority;
      end
      if (state_ff == ST_EXEC) begin
         popped_ff      <= popped_in;
         pop_valid_ff   <= pop_valid_in;
         ignored_ff     <= ignored_in;
         empty_err_ff   <= empty_err_in;
         total_ff       <= total_in;
         queue_empty_ff <= queue_empty_in;
      end
   end

   // Membership memory: one write port, registered read.
   always_ff @(posedge clock) begin
      if (member_we) begin
         member_mem[member_wa] <= member_wd;
      end
      member_rd_ff <= member_mem[AW'(req_node_index)];
   end

   // High-priority ring.
   always_ff @(posedge clock) begin
      if (high_we) begin
         high_mem[high_tail_ff] <= node_ff;
      end
      high_rd_ff <= high_mem[high_head_ff];
   end

   // Low-priority ring.
   always_ff @(posedge clock) begin
      if (low_we) begin
         low_mem[low_tail_ff] <= node_ff;
      end
      low_rd_ff <= low_mem[low_head_ff];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_popped_node     = popped_ff;
   assign rsp_pop_valid       = pop_valid_ff;
   assign rsp_push_ignored    = ignored_ff;
   assign rsp_pop_empty_error = empty_err_ff;
   assign rsp_queued_total    = total_ff;
   assign rsp_queue_empty     = queue_empty_ff;

   // An accepted item is always worked on in the following cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted item did not enter execution");

   // A result appears in the cycle after execution.
   a_result_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> rsp_valid_ff)
      else $error("execution produced no result");

   // The two FIFOs never hold more nodes than there are.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, high_count_ff} + {1'b0, low_count_ff}) <= (CW + 1)'(NODE_COUNT))
      else $error("queued node count exceeds node count");

   // The empty flag agrees with the reported total.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (queue_empty_ff == (total_ff == '0)))
      else $error("empty flag disagrees with total");

   // A returned node excludes both error flags.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pop_valid_ff) |-> (!ignored_ff && !empty_err_ff))
      else $error("pop result carries an error flag");

endmodule

@@ tb/sv/tb_dedup_two_level_work_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the deduplicating two-priority work queue
// Feeds push and pop items through the start/busy handshake. It keeps its own
// copy of both node FIFOs and the membership set to work out each result, and
// checks every result field against that copy, in order of issue.
// ----------------------------------------------------------------------------
module tb_dedup_two_level_work_queue;

   localparam int unsigned NODES       = dtwq_pkg::NODE_COUNT_DEFAULT;
   localparam int unsigned NW          = dtwq_pkg::NODE_WIDTH;
   localparam int unsigned TW          = dtwq_pkg::TOTAL_WIDTH;
   localparam int unsigned IDLE_PCT    = 24;
   // Items in this window are sent back to back, with no idle cycles.
   localparam int unsigned CALM_FIRST  = 1200;
   localparam int unsigned CALM_LAST   = 1700;
   // Covers the membership clearing pass after reset with a wide margin.
   localparam int unsigned STALL_LIMIT = 4 * NODES + 200;

   typedef struct packed {
      logic          opcode;
      logic [NW-1:0] node;
      logic          low_prio;
      logic          wait_drained;
   } queue_cmd_type;

   typedef struct packed {
      logic [NW-1:0] popped_node;
      logic          pop_valid;
      logic          push_ignored;
      logic          pop_empty_error;
      logic [TW-1:0] queued_total;
      logic          queue_empty;
   } queue_outcome_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   start            = 1'b0;
   logic                   req_opcode       = dtwq_pkg::OP_PUSH;
   logic [NW-1:0]          req_node_index   = '0;
   logic                   req_low_priority = 1'b0;
   logic                   busy;
   logic                   rsp_valid;
   logic [NW-1:0]          rsp_popped_node;
   logic                   rsp_pop_valid;
   logic                   rsp_push_ignored;
   logic                   rsp_pop_empty_error;
   logic [TW-1:0]          rsp_queued_total;
   logic                   rsp_queue_empty;

   // Shadow of the queue contents.
   bit                     queued_flag [NODES];
   logic [NW-1:0]          high_fifo [$];
   logic [NW-1:0]          low_fifo [$];

   queue_cmd_type          cmd_backlog [$];
   queue_outcome_type      outstanding_outcomes [$];
   queue_cmd_type          next_cmd;
   queue_outcome_type      oldest;
   logic                   item_taken     = 1'b0;
   int unsigned            issued_items   = 0;
   int unsigned            total_items    = 0;
   int unsigned            ops_accepted   = 0;
   int unsigned            outcomes_seen  = 0;
   int unsigned            dup_pushes     = 0;
   int unsigned            empty_pops     = 0;
   int unsigned            peak_depth     = 0;
   int unsigned            mismatches     = 0;
   int unsigned            stall_cycles   = 0;

   dedup_two_level_work_queue u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_node_index      (req_node_index),
      .req_low_priority    (req_low_priority),
      .rsp_valid           (rsp_valid),
      .rsp_popped_node     (rsp_popped_node),
      .rsp_pop_valid       (rsp_pop_valid),
      .rsp_push_ignored    (rsp_push_ignored),
      .rsp_pop_empty_error (rsp_pop_empty_error),
      .rsp_queued_total    (rsp_queued_total),
      .rsp_queue_empty     (rsp_queue_empty)
   );

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Applies one item to the shadow queue and returns the result it must give.
   function automatic queue_outcome_type run_queue_op(input queue_cmd_type cmd);
      queue_outcome_type res;
      int unsigned       depth;
      res = '0;
      if (cmd.opcode == dtwq_pkg::OP_PUSH) begin
         if (queued_flag[cmd.node]) begin
            res.push_ignored = 1'b1;
            dup_pushes++;
         end else begin
            queued_flag[cmd.node] = 1'b1;
            if (cmd.low_prio) begin
               low_fifo.push_back(cmd.node);
            end else begin
               high_fifo.push_back(cmd.node);
            end
         end
      end else begin
         // High priority is always served first.
         if (high_fifo.size() != 0) begin
            res.popped_node = high_fifo.pop_front();
            res.pop_valid   = 1'b1;
         end else if (low_fifo.size() != 0) begin
            res.popped_node = low_fifo.pop_front();
            res.pop_valid   = 1'b1;
         end else begin
            res.pop_empty_error = 1'b1;
            empty_pops++;
         end
         if (res.pop_valid) begin
            queued_flag[res.popped_node] = 1'b0;
         end
      end
      depth            = high_fifo.size() + low_fifo.size();
      res.queued_total = depth[TW-1:0];
      res.queue_empty  = (depth == 0);
      if (depth > peak_depth) begin
         peak_depth = depth;
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [TW-1:0] want,
                              input logic [TW-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic add_push(input int unsigned node, input bit low);
      queue_cmd_type cmd;
      cmd.opcode       = dtwq_pkg::OP_PUSH;
      cmd.node         = node[NW-1:0];
      cmd.low_prio     = low;
      cmd.wait_drained = 1'b0;
      cmd_backlog.push_back(cmd);
      total_items++;
   endtask

   // The node and priority fields carry random junk on a pop.
   task automatic add_pop();
      queue_cmd_type cmd;
      cmd.opcode       = dtwq_pkg::OP_POP;
      cmd.node         = NW'($urandom_range(NODES - 1));
      cmd.low_prio     = 1'($urandom_range(1));
      cmd.wait_drained = 1'b0;
      cmd_backlog.push_back(cmd);
      total_items++;
   endtask

   // Marker: the sender holds off until every outstanding result has come.
   task automatic add_drain_pause();
      queue_cmd_type cmd;
      cmd              = '0;
      cmd.wait_drained = 1'b1;
      cmd_backlog.push_back(cmd);
   endtask

   // Sender: a new item goes out at the falling edge once the last one is taken.
   always @(negedge clock) begin
      if (!reset && (!start || item_taken)) begin
         if (cmd_backlog.size() != 0 && cmd_backlog[0].wait_drained) begin
            if (outstanding_outcomes.size() == 0) begin
               void'(cmd_backlog.pop_front());
            end
            start <= 1'b0;
         end else if (cmd_backlog.size() != 0 &&
                      ((issued_items >= CALM_FIRST && issued_items < CALM_LAST) ||
                       $urandom_range(99) >= IDLE_PCT)) begin
            next_cmd = cmd_backlog.pop_front();
            req_opcode       <= next_cmd.opcode;
            req_node_index   <= next_cmd.node;
            req_low_priority <= next_cmd.low_prio;
            start            <= 1'b1;
            issued_items++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Receiver: check results first, then record the item taken at this edge.
   always @(posedge clock) begin
      item_taken <= start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            if (outstanding_outcomes.size() == 0) begin
               $error("result with no item outstanding: popped_node %0d", rsp_popped_node);
               mismatches++;
            end else begin
               oldest = outstanding_outcomes.pop_front();
               check_field("popped_node", TW'(oldest.popped_node),
                           TW'(rsp_popped_node));
               check_field("pop_valid", TW'(oldest.pop_valid), TW'(rsp_pop_valid));
               check_field("push_ignored", TW'(oldest.push_ignored),
                           TW'(rsp_push_ignored));
               check_field("pop_empty_error", TW'(oldest.pop_empty_error),
                           TW'(rsp_pop_empty_error));
               check_field("queued_total", oldest.queued_total, rsp_queued_total);
               check_field("queue_empty", TW'(oldest.queue_empty),
                           TW'(rsp_queue_empty));
               outcomes_seen++;
            end
         end
         if (start && !busy) begin
            next_cmd.opcode   = req_opcode;
            next_cmd.node     = req_node_index;
            next_cmd.low_prio = req_low_priority;
            outstanding_outcomes.push_back(run_queue_op(next_cmd));
            ops_accepted++;
         end
      end
   end

   // Watchdog on cycles in which neither an item nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without progress", stall_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // Directed: empty pop, field extremes, duplicates across priorities,
      // high-before-low ordering and re-queueing a node after its pop.
      add_pop();
      add_push(0, 1'b0);
      add_push(NODES - 1, 1'b1);
      add_push(0, 1'b1);
      add_push(NODES - 1, 1'b0);
      add_push(512, 1'b0);
      add_push(341, 1'b1);
      add_push(682, 1'b0);
      repeat (5) add_pop();
      add_pop();
      add_push(5, 1'b1);
      add_push(6, 1'b0);
      add_pop();
      add_pop();
      add_push(7, 1'b1);
      add_pop();
      add_push(7, 1'b1);
      add_pop();
      add_drain_pause();

      // Full initial fill in node order, mostly high priority, with stray
      // duplicate pushes mixed in.
      for (int unsigned n = 0; n < NODES; n++) begin
         add_push(n, $urandom_range(19) == 0);
         if ($urandom_range(19) == 0) begin
            add_push($urandom_range(n), 1'($urandom_range(1)));
         end
      end
      add_drain_pause();

      // Pop a quarter of the nodes back out, high priority first.
      repeat (NODES / 4) add_pop();

      // Mixed traffic around a small node pool so duplicates are common.
      for (int i = 0; i < 150; i++) begin
         if ($urandom_range(99) < 45) begin
            add_pop();
         end else if ($urandom_range(99) < 60) begin
            add_push($urandom_range(47), $urandom_range(99) < 30);
         end else begin
            add_push($urandom_range(NODES - 1), $urandom_range(99) < 30);
         end
      end

      // Hold reset, then let the sender run.
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      while (ops_accepted != total_items || outstanding_outcomes.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);

      $display("Checked %0d results from %0d items, %0d duplicate pushes and %0d empty pops.",
               outcomes_seen, ops_accepted, dup_pushes, empty_pops);
      $display("Queue filled to %0d nodes, partly drained, then mixed with duplicates.",
               peak_depth);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ dedup_two_level_work_queue.f @@
rtl/dtwq_pkg.sv
rtl/dedup_two_level_work_queue.sv
tb/sv/tb_dedup_two_level_work_queue.sv
